// ===== rtl/rtks_pkg.sv =====
`timescale 1ns / 1ps

package rtks_pkg;

    // Field widths fixed by the item and result formats.
    localparam int IdW    = 16;
    localparam int ValueW = 32;
    localparam int KW     = 6;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_OUTPUT_MODE = 2'd0,
        REG_MAXIMIZE    = 2'd1,
        REG_SUBSET_SIZE = 2'd2,
        REG_SUBSET_MODE = 2'd3
    } reg_index_t;

    // Output modes.
    localparam logic [1:0] OUT_VALUE  = 2'd0;
    localparam logic [1:0] OUT_RANK   = 2'd1;
    localparam logic [1:0] OUT_SELECT = 2'd2;

    // Subset modes.
    localparam logic [1:0] SUB_EXACT  = 2'd0;
    localparam logic [1:0] SUB_STRICT = 2'd1;
    localparam logic [1:0] SUB_LOOSE  = 2'd2;

    typedef struct packed {
        logic [IdW-1:0]           item_id;
        logic signed [ValueW-1:0] item_value;
        logic                     last_item;
    } item_t;

    typedef struct packed {
        logic [IdW-1:0]           out_id;
        logic signed [ValueW-1:0] result_value;
        logic                     last_result;
    } result_t;

    // True when score a ranks strictly better than score b.
    function automatic logic score_better(
        input logic signed [ValueW-1:0] a,
        input logic signed [ValueW-1:0] b,
        input logic                     maximize
    );
        logic r;
        begin
            r = maximize ? (a > b) : (a < b);
            return r;
        end
    endfunction

endpackage

// ===== rtl/rtks_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module rtks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rank_and_top_k_select.sv =====
`timescale 1ns / 1ps

// Rank and top-k select. Requests of (id, signed Q16.16 score) are loaded into
// a store of MAX_ITEMS entries, one per cycle, until the request marked last
// (requests beyond a full store are dropped, but a last marker still closes
// the set). The block then ranks each of the n stored items against all n
// with a single shared comparator, one item at a time, finds the cutoff in a
// second pass over the stored ranks, and emits one result per item in load
// order. It takes no new request until it has emitted the last result of
// the set. The result is the score, the 1-based rank, or a select flag
// against the cutoff, set by the configuration registers. The user must write
// them over the APB port only while the block is idle; the block itself
// does not enforce this.
module rank_and_top_k_select
    import rtks_pkg::*;
#(
    parameter int MAX_ITEMS = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    // Item requests.
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,

    // Result requests.
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int CMPW = (CW > KW) ? CW : KW;

    typedef enum logic [7:0] {
        S_LOAD    = 8'b0000_0001,
        S_FETCH_I = 8'b0000_0010,
        S_LOAD_I  = 8'b0000_0100,
        S_CMP     = 8'b0000_1000,
        S_CUT_RD  = 8'b0001_0000,
        S_CUT_CHK = 8'b0010_0000,
        S_EM_RD   = 8'b0100_0000,
        S_EM_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [1:0]    output_mode_reg;
    logic          maximize_reg;
    logic [KW-1:0] subset_size_reg;
    logic [1:0]    subset_mode_reg;

    // Control registers.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] n_reg;
    logic [AW-1:0] last_idx_reg;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    logic          cut_found_reg;
    logic          result_valid_reg;

    // Payload registers.
    logic signed [ValueW-1:0] vi_reg;
    logic [CW-1:0]            rank_reg;
    logic signed [ValueW-1:0] cut_val_reg;
    logic signed [ValueW-1:0] worst_val_reg;
    result_t                  result_reg;

    // Memory ports.
    logic [AW-1:0]     rd_addr;
    logic              load_we;
    logic              rank_we;
    logic [IdW-1:0]    id_rd;
    logic [ValueW-1:0] value_rd;
    logic [CW-1:0]     rank_rd;
    logic [CW-1:0]     rank_next;

    // Decoded conditions.
    logic                     accept;
    logic                     store_ok;
    logic                     cfg_write;
    logic signed [ValueW-1:0] vj;
    logic                     rank_inc;
    logic [CMPW-1:0]          k_ext;
    logic [CMPW-1:0]          rank_ext;
    logic signed [ValueW-1:0] cutoff;
    logic                     in_k;
    logic                     sel;
    logic                     out_load;
    result_t                  result_next;

    assign accept   = item_valid && item_ready;
    assign store_ok = count_reg < CW'(MAX_ITEMS);
    assign load_we  = accept && store_ok;

    // Stores for ids, scores and ranks.
    rtks_ram #(.WIDTH(IdW), .DEPTH(MAX_ITEMS)) u_id_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item.item_id),
        .raddr (rd_addr),
        .rdata (id_rd)
    );

    rtks_ram #(.WIDTH(ValueW), .DEPTH(MAX_ITEMS)) u_value_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item.item_value),
        .raddr (rd_addr),
        .rdata (value_rd)
    );

    rtks_ram #(.WIDTH(CW), .DEPTH(MAX_ITEMS)) u_rank_store (
        .clk   (clk),
        .we    (rank_we),
        .waddr (i_reg),
        .wdata (rank_next),
        .raddr (rd_addr),
        .rdata (rank_rd)
    );

    // Read address: the current item, or the comparison sweep during ranking.
    always_comb
    begin
        case (state_reg)
            S_LOAD_I: rd_addr = '0;
            S_CMP:    rd_addr = j_reg + AW'(1);
            default:  rd_addr = i_reg;
        endcase
    end

    // Rank step: a stored item counts against item i if it scores better, or
    // if it scores the same and was loaded earlier.
    assign vj       = value_rd;
    assign rank_inc = (j_reg != i_reg) &&
                      (score_better(vj, vi_reg, maximize_reg) ||
                       ((j_reg < i_reg) && (vj == vi_reg)));
    assign rank_next = rank_reg + CW'(rank_inc);
    assign rank_we   = (state_reg == S_CMP) && (j_reg == last_idx_reg);

    // A subset size of zero acts as one.
    assign k_ext    = (subset_size_reg == '0) ? CMPW'(1) : CMPW'(subset_size_reg);
    assign rank_ext = CMPW'(rank_rd);
    assign cutoff   = cut_found_reg ? cut_val_reg : worst_val_reg;
    assign in_k     = rank_ext <= k_ext;

    // Select flag.
    always_comb
    begin
        case (subset_mode_reg)
            SUB_EXACT:  sel = in_k;
            SUB_STRICT: sel = in_k && score_better(value_rd, cutoff, maximize_reg);
            SUB_LOOSE:  sel = !score_better(cutoff, value_rd, maximize_reg);
            default:    sel = 1'b0;
        endcase
    end

    // Result formatting.
    always_comb
    begin
        result_next.out_id      = id_rd;
        result_next.last_result = (i_reg == last_idx_reg);
        case (output_mode_reg)
            OUT_RANK:   result_next.result_value = ValueW'(rank_rd);
            OUT_SELECT: result_next.result_value = ValueW'(sel);
            default:    result_next.result_value = value_rd;
        endcase
    end

    assign out_load = (state_reg == S_EM_OUT) && (!result_valid_reg || result_ready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept && item.last_item)
                begin
                    state_next = S_FETCH_I;
                end
            end
            S_FETCH_I: state_next = S_LOAD_I;
            S_LOAD_I:  state_next = S_CMP;
            S_CMP:
            begin
                if (j_reg == last_idx_reg)
                begin
                    state_next = (i_reg == last_idx_reg) ? S_CUT_RD : S_FETCH_I;
                end
            end
            S_CUT_RD:  state_next = S_CUT_CHK;
            S_CUT_CHK:
            begin
                state_next = (i_reg == last_idx_reg) ? S_EM_RD : S_CUT_RD;
            end
            S_EM_RD:   state_next = S_EM_OUT;
            S_EM_OUT:
            begin
                if (out_load)
                begin
                    state_next = (i_reg == last_idx_reg) ? S_LOAD : S_EM_RD;
                end
            end
            default:   state_next = S_LOAD;
        endcase
    end

    assign item_ready = (state_reg == S_LOAD);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            n_reg            <= '0;
            last_idx_reg     <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            cut_found_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Loading and closing the set.
            if (accept)
            begin
                if (item.last_item)
                begin
                    count_reg    <= '0;
                    n_reg        <= store_ok ? count_reg + CW'(1) : count_reg;
                    last_idx_reg <= store_ok ? count_reg[AW-1:0] : AW'(MAX_ITEMS - 1);
                    i_reg        <= '0;
                end
                else if (store_ok)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end

            // Index counters through the rank, cutoff and emit passes.
            case (state_reg)
                S_LOAD_I: j_reg <= '0;
                S_CMP:
                begin
                    j_reg <= j_reg + AW'(1);
                    if (j_reg == last_idx_reg)
                    begin
                        i_reg         <= (i_reg == last_idx_reg) ? '0 : i_reg + AW'(1);
                        cut_found_reg <= 1'b0;
                    end
                end
                S_CUT_CHK:
                begin
                    i_reg <= (i_reg == last_idx_reg) ? '0 : i_reg + AW'(1);
                    if (rank_ext == k_ext)
                    begin
                        cut_found_reg <= 1'b1;
                    end
                end
                S_EM_OUT:
                begin
                    if (out_load)
                    begin
                        i_reg <= i_reg + AW'(1);
                    end
                end
                default: ;
            endcase

            // Output register.
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD_I)
        begin
            vi_reg   <= value_rd;
            rank_reg <= CW'(1);
        end
        else if (state_reg == S_CMP)
        begin
            rank_reg <= rank_next;
        end

        if (state_reg == S_CUT_CHK)
        begin
            if (rank_ext == k_ext)
            begin
                cut_val_reg <= value_rd;
            end
            if (rank_rd == n_reg)
            begin
                worst_val_reg <= value_rd;
            end
        end

        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration registers.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_mode_reg <= OUT_SELECT;
            maximize_reg    <= 1'b0;
            subset_size_reg <= KW'(1);
            subset_mode_reg <= SUB_EXACT;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[3:2]))
                REG_OUTPUT_MODE: output_mode_reg <= pwdata[1:0];
                REG_MAXIMIZE:    maximize_reg    <= pwdata[0];
                REG_SUBSET_SIZE: subset_size_reg <= pwdata[KW-1:0];
                REG_SUBSET_MODE: subset_mode_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index_t'(paddr[3:2]))
            REG_OUTPUT_MODE: prdata = 32'(output_mode_reg);
            REG_MAXIMIZE:    prdata = 32'(maximize_reg);
            REG_SUBSET_SIZE: prdata = 32'(subset_size_reg);
            REG_SUBSET_MODE: prdata = 32'(subset_mode_reg);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== sim/rank_select_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and configuration ports of the rank and top-k
// block. It keeps its own copy of the loaded set and of the registers, works
// out the results of every closed set, and compares each result request with
// the oldest outstanding prediction.
module rank_select_checker
    import rtks_pkg::*;
#(
    parameter int MAX_ITEMS = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item,

    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          expected_left,
    output int          mismatches,
    output int          results_seen
);

    // Register copies.
    logic [1:0]    cfg_out;
    logic          cfg_max;
    logic [KW-1:0] cfg_k;
    logic [1:0]    cfg_sub;

    // Loaded set.
    logic [IdW-1:0]           loaded_id    [MAX_ITEMS];
    logic signed [ValueW-1:0] loaded_value [MAX_ITEMS];
    int unsigned              loaded_rank  [MAX_ITEMS];
    int unsigned              loaded_count;

    // Results still owed by the block, oldest first.
    result_t expected_results [$];
    result_t want;
    int      fail_total;
    int      seen_total;

    assign mismatches   = fail_total;
    assign results_seen = seen_total;

    // True when score a ranks strictly ahead of score b.
    function automatic logic ranks_above(
        input logic signed [ValueW-1:0] a,
        input logic signed [ValueW-1:0] b
    );
        return cfg_max ? (a > b) : (a < b);
    endfunction

    // Ranks the loaded set, finds the cutoff and queues one result per item.
    function automatic void predict_results();
        int unsigned              k;
        int unsigned              cut_idx;
        int unsigned              worst_idx;
        int unsigned              r;
        logic signed [ValueW-1:0] cutoff;
        logic signed [ValueW-1:0] v;
        logic                     in_top;
        logic                     chosen;
        result_t                  res;

        for (int i = 0; i < loaded_count; i++)
        begin
            r = 1;
            for (int j = 0; j < loaded_count; j++)
            begin
                if (j != i && (ranks_above(loaded_value[j], loaded_value[i]) ||
                               (j < i && loaded_value[j] == loaded_value[i])))
                    r++;
            end
            loaded_rank[i] = r;
        end

        // A subset size of zero behaves as one.
        k = (cfg_k == 0) ? 1 : cfg_k;
        cut_idx = loaded_count;
        worst_idx = 0;
        for (int i = 0; i < loaded_count; i++)
        begin
            if (loaded_rank[i] == k)
                cut_idx = i;
            if (loaded_rank[i] == loaded_count)
                worst_idx = i;
        end
        // With fewer items than k, the worst score is the cutoff.
        cutoff = (cut_idx < loaded_count) ? loaded_value[cut_idx] : loaded_value[worst_idx];

        for (int i = 0; i < loaded_count; i++)
        begin
            v = loaded_value[i];
            in_top = (loaded_rank[i] <= k);
            res.out_id = loaded_id[i];
            res.last_result = (i + 1 == loaded_count);
            case (cfg_out)
                OUT_RANK:
                begin
                    res.result_value = loaded_rank[i];
                end
                OUT_SELECT:
                begin
                    case (cfg_sub)
                        SUB_EXACT:  chosen = in_top;
                        SUB_STRICT: chosen = in_top && ranks_above(v, cutoff);
                        SUB_LOOSE:  chosen = !ranks_above(cutoff, v);
                        default:    chosen = 1'b0;
                    endcase
                    res.result_value = chosen ? 32'sd1 : 32'sd0;
                end
                // The fourth output mode passes the score like the first.
                default:
                begin
                    res.result_value = v;
                end
            endcase
            expected_results = {expected_results, res};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_out = OUT_SELECT;
            cfg_max = 1'b0;
            cfg_k = KW'(1);
            cfg_sub = SUB_EXACT;
            loaded_count = 0;
            expected_results.delete();
            fail_total = 0;
            seen_total = 0;
            expected_left <= 0;
        end
        else
        begin
            // Compare a result request with the oldest prediction.
            if (result_valid && result_ready)
            begin
                seen_total++;
                if (expected_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: unexpected result id %h value %h last %b",
                                 $realtime, result.out_id, result.result_value,
                                 result.last_result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.out_id !== want.out_id ||
                        result.result_value !== want.result_value ||
                        result.last_result !== want.last_result)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: expected %h/%h/%b, got %h/%h/%b",
                                     $realtime, want.out_id, want.result_value,
                                     want.last_result, result.out_id,
                                     result.result_value, result.last_result);
                    end
                end
            end

            // Store an item request; a full store drops it, but a last marker
            // still closes the set.
            if (item_valid && item_ready)
            begin
                if (loaded_count < MAX_ITEMS)
                begin
                    loaded_id[loaded_count] = item.item_id;
                    loaded_value[loaded_count] = item.item_value;
                    loaded_count++;
                end
                if (item.last_item)
                begin
                    predict_results();
                    loaded_count = 0;
                end
            end

            // Register writes; bits above each field are ignored.
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_OUTPUT_MODE: cfg_out = pwdata[1:0];
                    REG_MAXIMIZE:    cfg_max = pwdata[0];
                    REG_SUBSET_SIZE: cfg_k = pwdata[KW-1:0];
                    REG_SUBSET_MODE: cfg_sub = pwdata[1:0];
                    default: ;
                endcase
            end

            expected_left <= expected_results.size();
        end
    end

endmodule

// ===== sim/tb_rank_and_top_k_select.sv =====
`timescale 1ns / 1ps

module tb_rank_and_top_k_select;
    import rtks_pkg::*;

    localparam int SLOTS       = 32;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 500;
    localparam int END_GUARD   = 1400;
    localparam int RAND_PHASES = 4;
    localparam int TIMEOUT_NS  = 5_000_000;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] OUT_VALUE_ALT = 2'd3;
    localparam logic [1:0] SUB_NONE      = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          expected_left;
    int          mismatches;
    int          results_seen;

    // Stimulus bookkeeping.
    item_t       batch [$];
    int unsigned tx_quiet;
    int unsigned rx_quiet;
    int          items_sent;
    int          sets_sent;
    int          settings_used;
    logic        hold_req;
    logic        hold_done;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rank_and_top_k_select #(
        .MAX_ITEMS (SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    rank_select_checker #(
        .MAX_ITEMS (SLOTS)
    ) i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .expected_left (expected_left),
        .mismatches    (mismatches),
        .results_seen  (results_seen)
    );

    // Idle draw: mostly a random idle gap, with occasional runs of no idling.
    function automatic int unsigned pick_gap(inout int unsigned quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            quiet = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Scores biased toward ties and the ends of the range.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:
            begin
                v = $urandom_range(0, 3);
                v = v << 16;
            end
            1:
            begin
                v = $urandom_range(0, 3);
                v = -(v << 16);
            end
            2:
            begin
                v = $urandom;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [KW-1:0] pick_k();
        case ($urandom_range(0, 4))
            0:       return KW'(0);
            1:       return KW'(1);
            2:       return KW'($urandom_range(2, 8));
            3:       return KW'(SLOTS);
            default: return KW'(63);
        endcase
    endfunction

    task automatic add_item(input logic [IdW-1:0] id, input logic [31:0] value);
        item_t it;
        it.item_id = id;
        it.item_value = value;
        it.last_item = 1'b0;
        batch = {batch, it};
    endtask

    task automatic add_random_items(input int n);
        for (int i = 0; i < n; i++)
            add_item(IdW'($urandom_range(0, 65535)), pick_value());
    endtask

    // Sends the queued set; the final request carries the last marker.
    task automatic send_set();
        int unsigned gap;
        batch[batch.size() - 1].last_item = 1'b1;
        foreach (batch[i])
        begin
            gap = pick_gap(tx_quiet);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item_valid <= 1'b1;
            item <= batch[i];
            do @(posedge clk); while (!item_ready);
            items_sent++;
        end
        sets_sent++;
        batch.delete();
    endtask

    // Waits until every predicted result has arrived and the block has settled.
    task automatic wait_idle();
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access cycle. The caller drops psel.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    // Writes all four registers, with junk in the unused upper bits.
    task automatic configure(input logic [1:0] out_mode, input logic max_first,
                             input logic [KW-1:0] k, input logic [1:0] sub_mode);
        wait_idle();
        write_reg(REG_OUTPUT_MODE, ({$urandom} << 2) | out_mode);
        write_reg(REG_MAXIMIZE, ({$urandom} << 1) | max_first);
        write_reg(REG_SUBSET_SIZE, ({$urandom} << KW) | k);
        write_reg(REG_SUBSET_MODE, ({$urandom} << 2) | sub_mode);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings_used++;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int unsigned stall;
        result_ready <= 1'b0;
        rx_quiet = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            stall = pick_gap(rx_quiet);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [1:0] om;
        int         phase_items;
        int         n;

        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        hold_req = 1'b0;
        tx_quiet = 0;
        items_sent = 0;
        sets_sent = 0;
        settings_used = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: a single item at the lowest score and highest id.
        add_item(16'hFFFF, 32'h8000_0000);
        send_set();

        // Ranks over both score extremes, a tie and id extremes.
        configure(OUT_RANK, 1'b0, KW'(2), SUB_EXACT);
        add_item(16'h0000, 32'h7FFF_FFFF);
        add_item(16'hFFFF, 32'h8000_0000);
        add_item(16'h5555, 32'h0000_0000);
        add_item(16'hAAAA, 32'h0000_0000);
        add_item(16'h0001, 32'hFFFF_FFFF);
        add_item(16'h8000, 32'h0001_0000);
        send_set();

        // Same set, maximizing, strict select with a subset size of zero.
        configure(OUT_SELECT, 1'b1, KW'(0), SUB_STRICT);
        add_item(16'h0000, 32'h7FFF_FFFF);
        add_item(16'hFFFF, 32'h8000_0000);
        add_item(16'h5555, 32'h0000_0000);
        add_item(16'hAAAA, 32'h0000_0000);
        add_item(16'h0001, 32'hFFFF_FFFF);
        add_item(16'h8000, 32'h0001_0000);
        send_set();

        // Loose select where the cutoff falls inside a run of equal scores.
        configure(OUT_SELECT, 1'b0, KW'(3), SUB_LOOSE);
        add_item(IdW'($urandom_range(0, 65535)), 32'h0005_0000);
        add_item(IdW'($urandom_range(0, 65535)), 32'h0005_0000);
        add_item(IdW'($urandom_range(0, 65535)), 32'h0005_0000);
        add_item(IdW'($urandom_range(0, 65535)), 32'h0001_0000);
        send_set();

        // Subset size above the count: exact takes all, strict all that beat the worst score.
        configure(OUT_SELECT, 1'b1, KW'(63), SUB_EXACT);
        add_random_items(2);
        send_set();
        configure(OUT_SELECT, 1'b0, KW'(SLOTS), SUB_STRICT);
        add_random_items(2);
        send_set();

        // Select nothing, and the fourth output mode passing the score.
        configure(OUT_SELECT, 1'b1, KW'(1), SUB_NONE);
        add_random_items(2);
        send_set();
        configure(OUT_VALUE_ALT, 1'b0, KW'(SLOTS), SUB_NONE);
        add_random_items(2);
        send_set();

        // Random sets under random settings.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       om = OUT_VALUE;
                1:       om = OUT_RANK;
                default: om = OUT_SELECT;
            endcase
            configure(om, 1'($urandom_range(0, 1)), pick_k(), 2'($urandom_range(0, 3)));
            phase_items = 0;
            while (phase_items < 8)
            begin
                n = $urandom_range(1, 8);
                add_random_items(n);
                send_set();
                phase_items += n;
            end
        end

        // One request more than the store holds; the dropped last one closes it.
        configure(OUT_RANK, 1'($urandom_range(0, 1)), pick_k(), 2'($urandom_range(0, 3)));
        add_random_items(SLOTS + 1);
        send_set();

        // Long result stall while further sets are offered back to back.
        configure(OUT_SELECT, 1'($urandom_range(0, 1)), pick_k(), 2'($urandom_range(0, 3)));
        hold_req = 1'b1;
        for (int s = 0; s < 3; s++)
        begin
            add_random_items(4);
            send_set();
        end

        wait_idle();
        repeat (END_GUARD) @(posedge clk);

        $display("Run covered %0d item requests in %0d sets under %0d register settings.",
                 items_sent, sets_sent, settings_used + 1);
        $display("%0d results compared, including store overflow and a long result stall.",
                 results_seen);
        if (mismatches == 0 && expected_left == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard limit on run time.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still expected.", expected_left);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rtks_pkg.sv
rtl/rtks_ram.sv
rtl/rank_and_top_k_select.sv
sim/rank_select_checker.sv
sim/tb_rank_and_top_k_select.sv
